>>> design/vkd_pkg.sv
// Shared types, codes and key tables for the videotex key sequence decoder.
package vkd_pkg;

   localparam logic [7:0] SS2_CODE   = 8'h19;
   localparam logic [7:0] FN_CODE    = 8'h13;
   localparam logic [7:0] ESC_CODE   = 8'h1B;
   localparam logic [7:0] PARITY_ERR = 8'hFF;

   localparam logic [15:0] ACCENT_GRV    = 16'h1941;
   localparam logic [15:0] ACCENT_ACUTE  = 16'h1942;
   localparam logic [15:0] ACCENT_CIRC   = 16'h1943;
   localparam logic [15:0] ACCENT_UMLAUT = 16'h1948;
   localparam logic [15:0] ACCENT_CEDIL  = 16'h194B;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } vkd_item_type;

   typedef struct packed {
      logic        emit;
      logic [23:0] key_code;
   } vkd_result_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } vkd_lut_type;

   function automatic logic [7:0] parity_decode(input logic [7:0] raw);
      if (raw[7] == ^raw[6:0]) begin
         return {1'b0, raw[6:0]};
      end
      return PARITY_ERR;
   endfunction

   function automatic logic is_accent(input logic [15:0] pair);
      return (pair == ACCENT_GRV) || (pair == ACCENT_ACUTE) || (pair == ACCENT_CIRC) ||
             (pair == ACCENT_UMLAUT) || (pair == ACCENT_CEDIL);
   endfunction

   function automatic vkd_lut_type two_key_lookup(input logic [15:0] pair);
      vkd_lut_type res;
      res.hit = 1'b1;
      case (pair)
         16'h1923: res.value = 8'hA3;
         16'h1927: res.value = 8'hA7;
         16'h1930: res.value = 8'hB0;
         16'h1931: res.value = 8'hB1;
         16'h1938: res.value = 8'hF7;
         16'h197B: res.value = 8'hDF;
         default: begin
            res.hit   = 1'b0;
            res.value = 8'h00;
         end
      endcase
      return res;
   endfunction

   function automatic vkd_lut_type three_key_lookup(input logic [23:0] triple);
      vkd_lut_type res;
      res.hit = 1'b1;
      case (triple)
         24'h194161: res.value = 8'hE0;
         24'h194165: res.value = 8'hE8;
         24'h194175: res.value = 8'hF9;
         24'h194265: res.value = 8'hE9;
         24'h194361: res.value = 8'hE2;
         24'h194365: res.value = 8'hEA;
         24'h194369: res.value = 8'hEE;
         24'h19436F: res.value = 8'hF4;
         24'h194375: res.value = 8'hFB;
         24'h194861: res.value = 8'hE4;
         24'h194865: res.value = 8'hEB;
         24'h194869: res.value = 8'hEF;
         24'h19486F: res.value = 8'hF6;
         24'h194875: res.value = 8'hFC;
         24'h194B63: res.value = 8'hE7;
         default: begin
            res.hit   = 1'b0;
            res.value = 8'h00;
         end
      endcase
      return res;
   endfunction

endpackage

>>> design/vkd_in_reg.sv
// Input word register with pass-through ready.
module vkd_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vkd_pkg::vkd_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output vkd_pkg::vkd_item_type item
);
   import vkd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   vkd_item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

>>> design/vkd_decode.sv
// Key sequence state machine: phase, gathered bytes and escape wait counter.
module vkd_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  vkd_pkg::vkd_item_type  item,
   input  logic [15:0]            esc_timeout,
   output vkd_pkg::vkd_result_type result
);
   import vkd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SS2_2,
      PH_SS2_3,
      PH_FN_2,
      PH_ESC_WAIT,
      PH_ESC_3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] partial_ff, partial_in;
   logic [15:0] wait_ff, wait_in;
   logic [7:0]  b;
   logic [15:0] pair;
   logic [15:0] wait_inc;
   vkd_lut_type two_hit;
   vkd_lut_type three_hit;

   always_comb begin
      b         = parity_decode(item.rx_byte);
      pair      = {partial_ff[7:0], b};
      two_hit   = two_key_lookup(pair);
      three_hit = three_key_lookup({partial_ff, b});
      wait_inc  = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;

      phase_in        = phase_ff;
      partial_in      = partial_ff;
      wait_in         = wait_ff;
      result.emit     = 1'b0;
      result.key_code = 24'h0;

      if (item.cmd) begin
         if (phase_ff == PH_ESC_WAIT) begin
            wait_in = wait_inc;
            if (wait_inc >= esc_timeout) begin
               result.emit     = 1'b1;
               result.key_code = {16'h0, ESC_CODE};
            end
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (b == SS2_CODE) begin
                  partial_in = {8'h0, b};
                  phase_in   = PH_SS2_2;
               end else if (b == FN_CODE) begin
                  partial_in = {8'h0, b};
                  phase_in   = PH_FN_2;
               end else if (b == ESC_CODE) begin
                  partial_in = {8'h0, b};
                  wait_in    = 16'h0;
                  phase_in   = PH_ESC_WAIT;
               end else begin
                  result.emit     = 1'b1;
                  result.key_code = {16'h0, b};
               end
            end
            PH_SS2_2: begin
               if (is_accent(pair)) begin
                  partial_in = pair;
                  phase_in   = PH_SS2_3;
               end else begin
                  result.emit     = 1'b1;
                  result.key_code = two_hit.hit ? {16'h0, two_hit.value} : {8'h0, pair};
               end
            end
            PH_SS2_3: begin
               result.emit     = 1'b1;
               result.key_code = {16'h0, three_hit.hit ? three_hit.value : b};
            end
            PH_FN_2: begin
               result.emit     = 1'b1;
               result.key_code = {8'h0, pair};
            end
            PH_ESC_WAIT: begin
               partial_in = pair;
               wait_in    = 16'h0;
               phase_in   = PH_ESC_3;
            end
            PH_ESC_3: begin
               result.emit     = 1'b1;
               result.key_code = {partial_ff, b};
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (result.emit) begin
         phase_in   = PH_IDLE;
         partial_in = 16'h0;
         wait_in    = 16'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         partial_ff <= 16'h0;
         wait_ff    <= 16'h0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
         wait_ff    <= wait_in;
      end
   end

endmodule

>>> design/videotex_key_sequence_decoder_core.sv
// Top level of the videotex key sequence decoder.
//
//   channel | ports                          | direction | moves
//   req     | req_valid/req_ready, req_*     | in        | one byte or tick word
//   rsp     | rsp_valid/rsp_ready, rsp_*     | out       | one key code word
//   csr     | csr_write_enable, csr_write_data | in      | escape timeout ticks
//
// One word per cycle while the output register is not stalled.
// The input register feeds the phase logic, whose result is held in the output register.
// A stalled output register holds the input register; the input side then drops ready.
// Reset returns to idle, clears the valid flags of both registers and sets the timeout to one tick.
module videotex_key_sequence_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_key_code,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import vkd_pkg::*;

   vkd_item_type   req_item;
   vkd_item_type   item;
   vkd_result_type result;
   logic           item_valid;
   logic           advance;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [23:0]    key_code_ff;
   logic [15:0]    esc_timeout_ff;

   assign req_item.cmd     = req_cmd;
   assign req_item.rx_byte = req_rx_byte;
   assign advance          = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = key_code_ff;

   vkd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vkd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (item),
      .esc_timeout (esc_timeout_ff),
      .result      (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && result.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         esc_timeout_ff <= 16'd1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            esc_timeout_ff <= csr_write_data;
         end
      end
      if (advance && result.emit) begin
         key_code_ff <= result.key_code;
      end
   end

endmodule

>>> design/vkd_checker.sv
// Port checker for the key sequence decoder and its bind.
module vkd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_key_code
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code))
      else $error("stalled rsp word changed");

   a_top_byte_esc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code[23:16] == 8'h00 || rsp_key_code[23:16] == 8'h1B)
      else $error("three-byte code without escape lead");

   a_mid_byte_lead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_code[23:16] == 8'h00 |->
         rsp_key_code[15:8] == 8'h00 || rsp_key_code[15:8] == 8'h19 ||
         rsp_key_code[15:8] == 8'h13)
      else $error("two-byte code with unknown lead");

endmodule

bind videotex_key_sequence_decoder_core vkd_checker u_vkd_checker (.*);
